// ===== rtl/core/ptsch_pkg.sv =====
// Shared types and constants of the priority task scheduler.
`timescale 1ns / 1ps

package ptsch_pkg;

  // Default table size and the widest slot number across the supported sizes (up to 64).
  localparam int MAX_TASKS_DEF = 8;
  localparam int SLOT_W        = 6;

  // Field widths of the request and result channels.
  localparam int MODE_W      = 2;
  localparam int PRIO_W      = 8;
  localparam int DUR_W       = 32;
  localparam int TGT_W       = 3;
  localparam int TIME_W      = 48;
  localparam int END_W       = TIME_W + 1;
  localparam int ALARM_W     = 32;
  localparam int PORT_SLOT_W = 3;

  localparam logic [ALARM_W-1:0] ALARM_RESET = 32'd60000;

  // Request modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_SLEEP = 2'd1,
    MODE_WAKE  = 2'd2,
    MODE_SCHED = 2'd3
  } mode_t;

  // Commands broadcast to the task cells.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_ADD    = 3'd1,
    OP_SLEEP  = 3'd2,
    OP_WAKE   = 3'd3,
    OP_REVIVE = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [PRIO_W-1:0] prio;
    logic [END_W-1:0]  end_ms;
  } cell_cmd_t;

  // Election record that travels down the chain, one cell per cycle.
  typedef struct packed {
    logic               vld;
    logic [PRIO_W-1:0]  best_prio;
    logic               act_found;
    logic [SLOT_W-1:0]  act_idx;
    logic               slp_found;
    logic [SLOT_W-1:0]  slp_idx;
    logic [ALARM_W-1:0] alarm;
  } scan_t;

endpackage

// ===== rtl/core/ptsch_cell.sv =====
// One task slot of the scheduler chain: task state plus one election step.
`timescale 1ns / 1ps

module ptsch_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptsch_pkg::cell_cmd_t        cmd,
  input  logic                        sel,
  input  logic [ptsch_pkg::TIME_W-1:0] now_ms,
  input  ptsch_pkg::scan_t            scan_in,
  output ptsch_pkg::scan_t            scan_out
);

  logic                            valid_r;
  logic [ptsch_pkg::PRIO_W-1:0]    prio_r;
  logic                            active_r;
  logic                            waiting_r;
  logic [ptsch_pkg::END_W-1:0]     end_r;
  ptsch_pkg::scan_t                scan_r;
  ptsch_pkg::scan_t                scan_nxt;

  logic [ptsch_pkg::END_W:0]       diff;
  logic                            expired;
  logic                            pending;
  logic                            eligible;
  logic                            nearer;

  // Compare the wake time against the election time
  assign diff     = {1'b0, end_r} - {2'b00, now_ms};
  assign expired  = diff[ptsch_pkg::END_W] || (diff == '0);
  assign pending  = waiting_r && !expired;
  assign eligible = valid_r && !pending && (prio_r > scan_in.best_prio);
  assign nearer   = valid_r && pending &&
                    (diff[ptsch_pkg::END_W-1:ptsch_pkg::ALARM_W] == '0) &&
                    (diff[ptsch_pkg::ALARM_W-1:0] < scan_in.alarm);

  // Fold this slot into the election record
  always_comb begin
    scan_nxt = scan_in;
    if (eligible) begin
      scan_nxt.best_prio = prio_r;
      if (active_r) begin
        scan_nxt.act_found = 1'b1;
        scan_nxt.act_idx   = ptsch_pkg::SLOT_W'(CELL_IDX);
      end else begin
        scan_nxt.slp_found = 1'b1;
        scan_nxt.slp_idx   = ptsch_pkg::SLOT_W'(CELL_IDX);
      end
    end
    if (nearer) begin
      scan_nxt.alarm = diff[ptsch_pkg::ALARM_W-1:0];
    end
  end

  // Hand the record to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign scan_out = scan_r;

  // Slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && (cmd.op == ptsch_pkg::OP_ADD)) begin
      valid_r <= 1'b1;
    end
  end

  // Apply commands; drop expired waits as the election passes
  always_ff @(posedge clk) begin
    if (sel) begin
      unique case (cmd.op)
        ptsch_pkg::OP_ADD: begin
          prio_r    <= cmd.prio;
          active_r  <= 1'b1;
          waiting_r <= 1'b0;
        end
        ptsch_pkg::OP_SLEEP: begin
          if (valid_r) begin
            active_r  <= 1'b0;
            waiting_r <= 1'b1;
            end_r     <= cmd.end_ms;
          end
        end
        ptsch_pkg::OP_WAKE: begin
          if (valid_r) begin
            active_r  <= 1'b1;
            waiting_r <= 1'b0;
          end
        end
        ptsch_pkg::OP_REVIVE: begin
          active_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end else if (scan_in.vld && valid_r && expired) begin
      waiting_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/priority_task_scheduler.sv =====
// Top level of the priority task scheduler: request handling, election control, result register.
`timescale 1ns / 1ps

// Each task slot is a cell in a chain; an election sends a record down the chain one cell per
// clock. A sleep, wake or schedule request runs an election through the whole chain before the
// next request can be taken, while an add or a zero-length sleep goes straight to its result. One
// request is in work at a time; its result sits in an output register, and the next request is
// accepted while that result waits to be taken. No clearing pass follows reset.

module priority_task_scheduler #(
  parameter int MAX_TASKS = ptsch_pkg::MAX_TASKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_wr_en,
  input  logic [ptsch_pkg::ALARM_W-1:0]     cfg_wr_data,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ptsch_pkg::MODE_W-1:0]      in_mode,
  input  logic [ptsch_pkg::PRIO_W-1:0]      in_priority_req,
  input  logic [ptsch_pkg::DUR_W-1:0]       in_duration_ms,
  input  logic [ptsch_pkg::TGT_W-1:0]       in_target_task,
  input  logic [ptsch_pkg::TIME_W-1:0]      in_now_ms,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_status,
  output logic [ptsch_pkg::PORT_SLOT_W-1:0] out_new_task,
  output logic [ptsch_pkg::PORT_SLOT_W-1:0] out_run_task,
  output logic                              out_run_is_idle,
  output logic                              out_woke_on_timeout,
  output logic [ptsch_pkg::ALARM_W-1:0]     out_alarm_ms
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                              state_r;
  logic [ptsch_pkg::ALARM_W-1:0]       alarm_cfg_r;
  logic [CNT_W-1:0]                    task_count_r;
  logic [IDX_W-1:0]                    running_slot_r;
  logic                                running_idle_r;
  logic [ptsch_pkg::TIME_W-1:0]        now_r;
  logic                                go_r;

  logic                                res_status_r;
  logic [ptsch_pkg::PORT_SLOT_W-1:0]   res_new_r;
  logic [ptsch_pkg::PORT_SLOT_W-1:0]   res_run_r;
  logic                                res_idle_r;
  logic                                res_woke_r;
  logic [ptsch_pkg::ALARM_W-1:0]       res_alarm_r;

  logic                                out_valid_r;
  logic                                out_status_r;
  logic [ptsch_pkg::PORT_SLOT_W-1:0]   out_new_task_r;
  logic [ptsch_pkg::PORT_SLOT_W-1:0]   out_run_task_r;
  logic                                out_run_is_idle_r;
  logic                                out_woke_r;
  logic [ptsch_pkg::ALARM_W-1:0]       out_alarm_r;

  ptsch_pkg::mode_t                    mode;
  logic                                in_acc;
  logic                                is_add;
  logic                                full;
  logic                                do_elect;
  logic                                fin;
  logic                                out_free;
  ptsch_pkg::cell_cmd_t                cmd;
  logic [MAX_TASKS-1:0]                cell_sel;
  ptsch_pkg::scan_t                    launch;
  ptsch_pkg::scan_t                    scan_w [0:MAX_TASKS];
  ptsch_pkg::scan_t                    last;

  logic [IDX_W-1:0]                    win_slot;
  logic                                win_idle;
  logic                                win_woke;

  assign mode     = ptsch_pkg::mode_t'(in_mode);
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_add   = (mode == ptsch_pkg::MODE_ADD);
  assign full     = (task_count_r >= CNT_W'(MAX_TASKS));
  assign do_elect = !is_add && !((mode == ptsch_pkg::MODE_SLEEP) && (in_duration_ms == '0));
  assign last     = scan_w[MAX_TASKS];
  assign fin      = (state_r == S_SCAN) && last.vld;
  assign out_free = !out_valid_r || !out_stall;

  // Build the cell command and the slot select
  always_comb begin
    cmd.op     = ptsch_pkg::OP_NONE;
    cmd.prio   = in_priority_req;
    cmd.end_ms = {1'b0, in_now_ms} + ptsch_pkg::END_W'(in_duration_ms);
    if (in_acc) begin
      unique case (mode)
        ptsch_pkg::MODE_ADD: begin
          if (!full) cmd.op = ptsch_pkg::OP_ADD;
        end
        ptsch_pkg::MODE_SLEEP: begin
          if ((in_duration_ms != '0) && !running_idle_r) cmd.op = ptsch_pkg::OP_SLEEP;
        end
        ptsch_pkg::MODE_WAKE: begin
          cmd.op = ptsch_pkg::OP_WAKE;
        end
        ptsch_pkg::MODE_SCHED: begin
        end
      endcase
    end else if (fin && !last.act_found && last.slp_found) begin
      cmd.op = ptsch_pkg::OP_REVIVE;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      unique case (cmd.op)
        ptsch_pkg::OP_ADD:    cell_sel[i] = (task_count_r == CNT_W'(i));
        ptsch_pkg::OP_SLEEP:  cell_sel[i] = (running_slot_r == IDX_W'(i));
        ptsch_pkg::OP_WAKE:   cell_sel[i] = (32'(in_target_task) == 32'(i));
        ptsch_pkg::OP_REVIVE: cell_sel[i] = (last.slp_idx == ptsch_pkg::SLOT_W'(i));
        default:              cell_sel[i] = 1'b0;
      endcase
    end
  end

  // Launch record for the election
  always_comb begin
    launch       = '0;
    launch.vld   = go_r;
    launch.alarm = alarm_cfg_r;
  end

  assign scan_w[0] = launch;

  // Chain of task cells
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    ptsch_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (cell_sel[g]),
      .now_ms   (now_r),
      .scan_in  (scan_w[g]),
      .scan_out (scan_w[g+1])
    );
  end

  // Pick the winner: active first, then a timed-out sleeper, else idle
  always_comb begin
    win_slot = '0;
    win_idle = 1'b1;
    win_woke = 1'b0;
    if (last.act_found) begin
      win_slot = last.act_idx[IDX_W-1:0];
      win_idle = 1'b0;
    end else if (last.slp_found) begin
      win_slot = last.slp_idx[IDX_W-1:0];
      win_idle = 1'b0;
      win_woke = 1'b1;
    end
  end

  // Sequence requests and hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      alarm_cfg_r    <= ptsch_pkg::ALARM_RESET;
      task_count_r   <= '0;
      running_slot_r <= '0;
      running_idle_r <= 1'b1;
      go_r           <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (cfg_wr_en) alarm_cfg_r <= cfg_wr_data;
      if (out_free) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            now_r <= in_now_ms;
            if (do_elect) begin
              go_r    <= 1'b1;
              state_r <= S_SCAN;
            end else begin
              res_status_r <= is_add && full;
              res_new_r    <= (is_add && !full) ? ptsch_pkg::PORT_SLOT_W'(task_count_r) : '0;
              res_run_r    <= ptsch_pkg::PORT_SLOT_W'(running_slot_r);
              res_idle_r   <= running_idle_r;
              res_woke_r   <= 1'b0;
              res_alarm_r  <= alarm_cfg_r;
              if (is_add && !full) task_count_r <= task_count_r + CNT_W'(1);
              state_r      <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (last.vld) begin
            running_slot_r <= win_slot;
            running_idle_r <= win_idle;
            res_status_r   <= 1'b0;
            res_new_r      <= '0;
            res_run_r      <= ptsch_pkg::PORT_SLOT_W'(win_slot);
            res_idle_r     <= win_idle;
            res_woke_r     <= win_woke;
            res_alarm_r    <= last.alarm;
            state_r        <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_status_r      <= res_status_r;
            out_new_task_r    <= res_new_r;
            out_run_task_r    <= res_run_r;
            out_run_is_idle_r <= res_idle_r;
            out_woke_r        <= res_woke_r;
            out_alarm_r       <= res_alarm_r;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_new_task        = out_new_task_r;
  assign out_run_task        = out_run_task_r;
  assign out_run_is_idle     = out_run_is_idle_r;
  assign out_woke_on_timeout = out_woke_r;
  assign out_alarm_ms        = out_alarm_r;

endmodule

// ===== sim/priority_task_scheduler_tb.sv =====
// Self-checking testbench for the priority task scheduler: scoreboard, request driver, result check.
`timescale 1ns / 1ps

module priority_task_scheduler_tb;

  localparam int NUM_SLOTS        = 8;
  localparam int NUM_PHASES       = 6;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int SETTLE_CYCLES    = NUM_SLOTS + 6;
  localparam logic [ptsch_pkg::TIME_W-1:0] TIME_MAX = '1;

  // Mirror the task table and queue the result due for each accepted request.
  class sched_scoreboard;
    typedef struct packed {
      logic                              status;
      logic [ptsch_pkg::PORT_SLOT_W-1:0] new_task;
      logic [ptsch_pkg::PORT_SLOT_W-1:0] run_task;
      logic                              run_is_idle;
      logic                              woke;
      logic [ptsch_pkg::ALARM_W-1:0]     alarm;
    } sched_result_t;

    logic [ptsch_pkg::ALARM_W-1:0] alarm_cap;
    logic                          slot_used   [NUM_SLOTS];
    logic [ptsch_pkg::PRIO_W-1:0]  slot_prio   [NUM_SLOTS];
    logic                          slot_active [NUM_SLOTS];
    logic [ptsch_pkg::TIME_W-1:0]  slot_start  [NUM_SLOTS];
    logic [ptsch_pkg::DUR_W-1:0]   slot_nap    [NUM_SLOTS];
    int                            task_count;
    int                            run_slot;
    logic                          run_idle;
    sched_result_t                 results_due[$];
    int                            errors;
    int                            checked;
    int                            woke_count;
    int                            full_count;
    int                            idle_count;

    function new();
      alarm_cap = ptsch_pkg::ALARM_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_used[i]   = 1'b0;
        slot_prio[i]   = '0;
        slot_active[i] = 1'b0;
        slot_start[i]  = '0;
        slot_nap[i]    = '0;
      end
      task_count = 0;
      run_slot   = 0;
      run_idle   = 1'b1;
      errors     = 0;
      checked    = 0;
      woke_count = 0;
      full_count = 0;
      idle_count = 0;
    endfunction

    function void set_alarm_cap(logic [ptsch_pkg::ALARM_W-1:0] cap);
      alarm_cap = cap;
    endfunction

    // Clear expired waits, pick the runner and return the capped alarm.
    function logic [ptsch_pkg::ALARM_W-1:0] elect(logic [ptsch_pkg::TIME_W-1:0] now,
                                                  output logic woke);
      logic [ptsch_pkg::PRIO_W-1:0]  best;
      int                            act;
      int                            slp;
      logic [ptsch_pkg::ALARM_W-1:0] alarm;
      logic [ptsch_pkg::END_W-1:0]   fin;
      logic [ptsch_pkg::END_W-1:0]   diff;
      best  = '0;
      act   = -1;
      slp   = -1;
      alarm = alarm_cap;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!slot_used[i])
          continue;
        fin = {1'b0, slot_start[i]} + ptsch_pkg::END_W'(slot_nap[i]);
        if (fin <= {1'b0, now})
          slot_nap[i] = '0;
        if (slot_nap[i] == '0 && slot_prio[i] > best) begin
          best = slot_prio[i];
          if (slot_active[i])
            act = i;
          else
            slp = i;
        end
        if (slot_nap[i] != '0) begin
          diff = fin - {1'b0, now};
          if (diff < ptsch_pkg::END_W'(alarm))
            alarm = diff[ptsch_pkg::ALARM_W-1:0];
        end
      end
      woke = 1'b0;
      if (act >= 0) begin
        run_slot = act;
        run_idle = 1'b0;
      end else if (slp >= 0) begin
        // Revive the sleeper whose wait ran out
        run_slot         = slp;
        run_idle         = 1'b0;
        slot_active[slp] = 1'b1;
        slot_start[slp]  = '0;
        woke             = 1'b1;
      end else begin
        run_slot = 0;
        run_idle = 1'b1;
      end
      return alarm;
    endfunction

    // Apply one accepted request and queue its result.
    function void note_request(ptsch_pkg::mode_t mode, logic [ptsch_pkg::PRIO_W-1:0] prio,
                               logic [ptsch_pkg::DUR_W-1:0] dur,
                               logic [ptsch_pkg::TGT_W-1:0] target,
                               logic [ptsch_pkg::TIME_W-1:0] now);
      sched_result_t r;
      logic          run_election;
      logic          woke;
      r            = '0;
      r.alarm      = alarm_cap;
      run_election = 1'b1;
      woke         = 1'b0;
      case (mode)
        ptsch_pkg::MODE_ADD: begin
          run_election = 1'b0;
          if (task_count >= NUM_SLOTS) begin
            r.status = 1'b1;
            full_count++;
          end else begin
            slot_used[task_count]   = 1'b1;
            slot_prio[task_count]   = prio;
            slot_active[task_count] = 1'b1;
            slot_start[task_count]  = '0;
            slot_nap[task_count]    = '0;
            r.new_task              = ptsch_pkg::PORT_SLOT_W'(task_count);
            task_count++;
          end
        end
        ptsch_pkg::MODE_SLEEP: begin
          if (dur == '0)
            run_election = 1'b0;
          else if (!run_idle && slot_used[run_slot]) begin
            slot_active[run_slot] = 1'b0;
            slot_start[run_slot]  = now;
            slot_nap[run_slot]    = dur;
          end
        end
        ptsch_pkg::MODE_WAKE: begin
          if (slot_used[target]) begin
            slot_nap[target]    = '0;
            slot_active[target] = 1'b1;
          end
        end
        default: ;
      endcase
      if (run_election)
        r.alarm = elect(now, woke);
      r.run_task    = ptsch_pkg::PORT_SLOT_W'(run_slot);
      r.run_is_idle = run_idle;
      r.woke        = woke;
      if (woke)
        woke_count++;
      if (run_election && run_idle)
        idle_count++;
      results_due.push_back(r);
    endfunction

    // Compare one taken result with the oldest one due.
    function void check_result(logic status, logic [ptsch_pkg::PORT_SLOT_W-1:0] new_task,
                               logic [ptsch_pkg::PORT_SLOT_W-1:0] run_task, logic run_is_idle,
                               logic woke, logic [ptsch_pkg::ALARM_W-1:0] alarm);
      sched_result_t e;
      if (results_due.size() == 0) begin
        $error("result with no request outstanding: run_task %0d alarm_ms %0d", run_task, alarm);
        errors++;
        return;
      end
      e = results_due.pop_front();
      checked++;
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (new_task !== e.new_task) begin
        $error("new_task: expected %0d, got %0d", e.new_task, new_task);
        errors++;
      end
      if (run_task !== e.run_task) begin
        $error("run_task: expected %0d, got %0d", e.run_task, run_task);
        errors++;
      end
      if (run_is_idle !== e.run_is_idle) begin
        $error("run_is_idle: expected %0d, got %0d", e.run_is_idle, run_is_idle);
        errors++;
      end
      if (woke !== e.woke) begin
        $error("woke_on_timeout: expected %0d, got %0d", e.woke, woke);
        errors++;
      end
      if (alarm !== e.alarm) begin
        $error("alarm_ms: expected %0d, got %0d", e.alarm, alarm);
        errors++;
      end
    endfunction

    // Earliest wait end still ahead of now; all ones when nothing waits.
    function logic [ptsch_pkg::END_W-1:0] nearest_deadline(logic [ptsch_pkg::TIME_W-1:0] now);
      logic [ptsch_pkg::END_W-1:0] due;
      logic [ptsch_pkg::END_W-1:0] fin;
      due = '1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        fin = {1'b0, slot_start[i]} + ptsch_pkg::END_W'(slot_nap[i]);
        if (slot_used[i] && slot_nap[i] != '0 && fin > {1'b0, now} && fin < due)
          due = fin;
      end
      return due;
    endfunction

    function int outstanding();
      return results_due.size();
    endfunction
  endclass

  logic                              clk             = 1'b0;
  logic                              rst_n           = 1'b0;
  logic                              cfg_wr_en       = 1'b0;
  logic [ptsch_pkg::ALARM_W-1:0]     cfg_wr_data     = '0;
  logic                              in_valid        = 1'b0;
  logic                              in_stall;
  logic [ptsch_pkg::MODE_W-1:0]      in_mode         = ptsch_pkg::MODE_ADD;
  logic [ptsch_pkg::PRIO_W-1:0]      in_priority_req = '0;
  logic [ptsch_pkg::DUR_W-1:0]       in_duration_ms  = '0;
  logic [ptsch_pkg::TGT_W-1:0]       in_target_task  = '0;
  logic [ptsch_pkg::TIME_W-1:0]      in_now_ms       = '0;
  logic                              out_valid;
  logic                              out_stall       = 1'b0;
  logic                              out_status;
  logic [ptsch_pkg::PORT_SLOT_W-1:0] out_new_task;
  logic [ptsch_pkg::PORT_SLOT_W-1:0] out_run_task;
  logic                              out_run_is_idle;
  logic                              out_woke_on_timeout;
  logic [ptsch_pkg::ALARM_W-1:0]     out_alarm_ms;

  sched_scoreboard              sb;
  logic [ptsch_pkg::TIME_W-1:0] now_ms = '0;
  int                           cycles = 0;
  int                           stall_left = 0;
  int                           requests_sent = 0;
  logic                         steady = 1'b0;

  priority_task_scheduler #(
    .MAX_TASKS(NUM_SLOTS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_priority_req     (in_priority_req),
    .in_duration_ms      (in_duration_ms),
    .in_target_task      (in_target_task),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_new_task        (out_new_task),
    .out_run_task        (out_run_task),
    .out_run_is_idle     (out_run_is_idle),
    .out_woke_on_timeout (out_woke_on_timeout),
    .out_alarm_ms        (out_alarm_ms)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Switch between stretches without idling and stretches with random gaps
  always @(posedge clk) begin
    if (cycles % 200 == 0)
      steady <= ($urandom_range(0, 2) == 0);
  end

  // Take results, check them and stall at random
  always @(posedge clk) begin : result_side
    int pick;
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_new_task, out_run_task, out_run_is_idle,
                      out_woke_on_timeout, out_alarm_ms);
    pick = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else if (pick < 3) begin
      stall_left <= $urandom_range(10, 40);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= (pick < 30);
    end
  end

  // Drive one request at now_ms after a random gap and hold it until taken.
  task automatic send_request(input ptsch_pkg::mode_t mode,
                              input logic [ptsch_pkg::PRIO_W-1:0] prio,
                              input logic [ptsch_pkg::DUR_W-1:0] dur,
                              input logic [ptsch_pkg::TGT_W-1:0] target);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55)
      gap = 0;
    else if (pick < 92)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_priority_req <= prio;
    in_duration_ms  <= dur;
    in_target_task  <= target;
    in_now_ms       <= now_ms;
    do @(posedge clk); while (in_stall);
    sb.note_request(mode, prio, dur, target, now_ms);
    requests_sent++;
  endtask

  // Hold off new requests until every result is in and the block has settled.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_alarm_cap(input logic [ptsch_pkg::ALARM_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    sb.set_alarm_cap(cap);
    cfg_wr_en <= 1'b0;
  endtask

  // Pick a random request; often land exactly on, or just short of, a wait end.
  task automatic send_random_request();
    ptsch_pkg::mode_t            mode;
    logic [ptsch_pkg::DUR_W-1:0] dur;
    logic [ptsch_pkg::END_W-1:0] due;
    logic [ptsch_pkg::END_W-1:0] next_now;
    int                          pick;
    pick = $urandom_range(0, 99);
    mode = (pick < 10) ? ptsch_pkg::MODE_ADD : (pick < 45) ? ptsch_pkg::MODE_SLEEP :
           (pick < 65) ? ptsch_pkg::MODE_WAKE : ptsch_pkg::MODE_SCHED;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      dur = '0;
    else if (pick < 80)
      dur = $urandom_range(1, 200);
    else if (pick < 93)
      dur = $urandom_range(200, 5000);
    else
      dur = $urandom();
    pick = $urandom_range(0, 99);
    due  = sb.nearest_deadline(now_ms);
    if (pick < 15 && due != '1 && due - {1'b0, now_ms} < ptsch_pkg::END_W'(1 << 20))
      next_now = due - ptsch_pkg::END_W'(pick < 5);
    else if (pick < 30)
      next_now = {1'b0, now_ms};
    else if (pick < 85)
      next_now = {1'b0, now_ms} + ptsch_pkg::END_W'($urandom_range(1, 50));
    else
      next_now = {1'b0, now_ms} + ptsch_pkg::END_W'($urandom_range(50, 3000));
    now_ms = (next_now > {1'b0, TIME_MAX}) ? TIME_MAX : next_now[ptsch_pkg::TIME_W-1:0];
    send_request(mode, ptsch_pkg::PRIO_W'($urandom()), dur, ptsch_pkg::TGT_W'($urandom()));
    if ($urandom_range(0, 99) == 0)
      drain_results();
  endtask

  initial begin : stimulus
    logic [ptsch_pkg::ALARM_W-1:0] caps [NUM_PHASES];
    sb = new();
    caps[0] = 32'd1;
    caps[1] = 32'hFFFF_FFFF;
    caps[2] = 32'd100;
    caps[3] = $urandom_range(2, 5000);
    caps[4] = $urandom();
    if (caps[4] == '0)
      caps[4] = 32'd1;
    caps[5] = ptsch_pkg::ALARM_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: idle wins, sleep while idle, wake of an empty slot, zero-length sleep
    now_ms = 48'd0;
    send_request(ptsch_pkg::MODE_SCHED, 8'd0, 32'd0, 3'd0);
    send_request(ptsch_pkg::MODE_SLEEP, 8'd0, 32'd100, 3'd0);
    now_ms = 48'd1;
    send_request(ptsch_pkg::MODE_WAKE, 8'd0, 32'd0, 3'd5);
    send_request(ptsch_pkg::MODE_SLEEP, 8'd0, 32'd0, 3'd0);
    // Priority 0 never runs; equal priorities go to the lower slot
    send_request(ptsch_pkg::MODE_ADD, 8'd0, 32'd0, 3'd0);
    now_ms = 48'd2;
    send_request(ptsch_pkg::MODE_SCHED, 8'd0, 32'd0, 3'd0);
    send_request(ptsch_pkg::MODE_ADD, 8'd5, 32'd0, 3'd0);
    send_request(ptsch_pkg::MODE_ADD, 8'd5, 32'd0, 3'd0);
    send_request(ptsch_pkg::MODE_ADD, 8'd255, 32'd0, 3'd0);
    now_ms = 48'd3;
    send_request(ptsch_pkg::MODE_SCHED, 8'd0, 32'd0, 3'd0);
    // Sleep the runners in turn, one for the longest wait
    now_ms = 48'd10;
    send_request(ptsch_pkg::MODE_SLEEP, 8'd0, 32'd50, 3'd0);
    send_request(ptsch_pkg::MODE_SLEEP, 8'd0, 32'hFFFF_FFFF, 3'd0);
    now_ms = 48'd20;
    send_request(ptsch_pkg::MODE_SLEEP, 8'd0, 32'd20, 3'd0);
    // Timeout wake, then a wait ending exactly at now behind an active task
    now_ms = 48'd59;
    send_request(ptsch_pkg::MODE_SCHED, 8'd0, 32'd0, 3'd0);
    now_ms = 48'd60;
    send_request(ptsch_pkg::MODE_SCHED, 8'd0, 32'd0, 3'd0);
    send_request(ptsch_pkg::MODE_WAKE, 8'd0, 32'd0, 3'd3);
    now_ms = 48'd61;
    send_request(ptsch_pkg::MODE_WAKE, 8'd0, 32'd0, 3'd1);
    // Fill the table, overflow it, and try a zero-length sleep while a task runs
    send_request(ptsch_pkg::MODE_ADD, 8'd200, 32'd0, 3'd0);
    send_request(ptsch_pkg::MODE_ADD, 8'd1, 32'd0, 3'd0);
    send_request(ptsch_pkg::MODE_ADD, 8'd128, 32'd0, 3'd0);
    send_request(ptsch_pkg::MODE_ADD, 8'hAA, 32'd0, 3'd0);
    send_request(ptsch_pkg::MODE_ADD, 8'd99, 32'd0, 3'd0);
    send_request(ptsch_pkg::MODE_SLEEP, 8'd0, 32'd0, 3'd0);
    drain_results();

    // Random traffic under each alarm setting; the last phase runs near the top of time
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1)
        now_ms = TIME_MAX - 48'd250000;
      write_alarm_cap(caps[p]);
      repeat (RANDOM_PER_PHASE) send_random_request();
      drain_results();
    end
    now_ms = TIME_MAX;
    send_request(ptsch_pkg::MODE_SCHED, 8'hFF, 32'hFFFF_FFFF, 3'd7);
    drain_results();

    $display("Ran %0d requests under %0d alarm settings up to time %0d ms; %0d results checked.",
             requests_sent, NUM_PHASES + 1, now_ms, sb.checked);
    $display("Saw %0d timeout wake-ups, %0d idle elections, %0d adds to a full table; %0d errors.",
             sb.woke_count, sb.idle_count, sb.full_count, sb.errors);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
